### hdl/itps_pkg.sv
package itps_pkg;

   localparam int RoomAccumWidth = 12;
   localparam int ReadingWidth   = 10;
   localparam int TipWidth       = 15;
   localparam int RoomWidth      = 11;
   localparam int DutyWidth      = 24;
   localparam int CsrIndexWidth  = 3;
   localparam int CsrDataWidth   = 16;

   localparam logic [CsrIndexWidth-1:0] CSR_SENSOR_TYPE = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_SOFT_GAIN   = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_SOFT_OFFSET = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_DERIV_GAIN  = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_PROP_COEFF  = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_PREV_COEFF  = 3'd5;

   localparam logic [15:0] SOFT_GAIN_RESET = 16'd1024;
   localparam logic [10:0] ROOM_BIAS       = 11'd125;
   localparam logic [16:0] ROOM_SCALE      = 17'd182;
   localparam logic [23:0] DUTY_FULL       = 24'hFF_FFFF;
   localparam logic signed [14:0] OVER_FORCE_LIMIT = -15'sd200;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ROOM, ST_TIP, ST_WIN, ST_SLOPE, ST_DMUL, ST_ERR, ST_PCUR, ST_PPREV,
      ST_DUTY
   } state_type;

   typedef enum logic [2:0] {
      MUL_ROOM, MUL_TIP, MUL_DTERM, MUL_CUR, MUL_PREV
   } mul_sel_type;

   typedef struct packed {
      logic        load_in;
      mul_sel_type mul_sel;
      logic        do_room;
      logic        do_win;
      logic        do_slope;
      logic        do_err;
      logic        do_sum;
      logic        finish;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

### hdl/itps_if.sv
interface itps_req_if;
   import itps_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [RoomAccumWidth-1:0] room_accum;
   logic [ReadingWidth-1:0]   couple_reading;
   logic [ReadingWidth-1:0]   resistive_reading;
   logic [ReadingWidth-1:0]   target_temp;
   modport source (output valid, room_accum, couple_reading, resistive_reading, target_temp,
                   input ready);
   modport sink (input valid, room_accum, couple_reading, resistive_reading, target_temp,
                 output ready);
endinterface

interface itps_rsp_if;
   import itps_pkg::*;
   logic                        valid;
   logic                        ready;
   logic [TipWidth-1:0]         tip_temp;
   logic signed [RoomWidth-1:0] room_temp;
   logic [DutyWidth-1:0]        duty;
   modport source (output valid, tip_temp, room_temp, duty, input ready);
   modport sink (input valid, tip_temp, room_temp, duty, output ready);
endinterface

### hdl/iron_temperature_pid_step.sv
// Soldering-iron temperature step: each request transaction yields one response with
// the tip temperature, room temperature and the updated 24-bit heater duty. The response
// is presented after nine sequencer steps around a single shared 17x17 signed multiplier
// that handles the room scale, tip gain, slope term and both PID products. A new request
// is taken once the result has been loaded into the response register, which may still
// be waiting on the sink; a busy response register holds the last step. The first
// request after reset primes the averaging windows. Configuration writes are taken any
// cycle but belong only in idle periods.
module iron_temperature_pid_step (
   input  logic                               clock,
   input  logic                               reset,
   itps_req_if.sink                           req,
   itps_rsp_if.source                         rsp,
   input  logic                               csr_we,
   input  logic [itps_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [itps_pkg::CsrDataWidth-1:0]  csr_data
);
   import itps_pkg::*;

   cmd_type    cmd;
   status_type status;

   itps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   itps_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .in_room_accum        (req.room_accum),
      .in_couple_reading    (req.couple_reading),
      .in_resistive_reading (req.resistive_reading),
      .in_target_temp       (req.target_temp),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .out_ready            (rsp.ready),
      .out_valid            (rsp.valid),
      .out_tip_temp         (rsp.tip_temp),
      .out_room_temp        (rsp.room_temp),
      .out_duty             (rsp.duty)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("request accepted while a transaction is in flight");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(cmd.finish))
      else $error("response raised without a finish step");

   a_finish_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp.valid || rsp.ready))
      else $error("result loaded over an untaken response");

endmodule

### hdl/itps_ctrl.sv
module itps_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  itps_pkg::status_type   status,
   output itps_pkg::cmd_type      cmd
);
   import itps_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_ROOM;
         ST_ROOM:  state_in = ST_TIP;
         ST_TIP:   state_in = ST_WIN;
         ST_WIN:   state_in = ST_SLOPE;
         ST_SLOPE: state_in = ST_DMUL;
         ST_DMUL:  state_in = ST_ERR;
         ST_ERR:   state_in = ST_PCUR;
         ST_PCUR:  state_in = ST_PPREV;
         ST_PPREV: state_in = ST_DUTY;
         ST_DUTY:  if (status.out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.mul_sel = MUL_ROOM;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.load_in = req_valid;
         end
         ST_ROOM:  cmd.mul_sel = MUL_ROOM;
         ST_TIP: begin
            cmd.mul_sel = MUL_TIP;
            cmd.do_room = 1'b1;
         end
         ST_WIN:   cmd.do_win = 1'b1;
         ST_SLOPE: cmd.do_slope = 1'b1;
         ST_DMUL:  cmd.mul_sel = MUL_DTERM;
         ST_ERR:   cmd.do_err = 1'b1;
         ST_PCUR:  cmd.mul_sel = MUL_CUR;
         ST_PPREV: begin
            cmd.mul_sel = MUL_PREV;
            cmd.do_sum  = 1'b1;
         end
         ST_DUTY: begin
            // keep the previous-error product stable while the response slot is busy
            cmd.mul_sel = MUL_PREV;
            cmd.finish  = status.out_free;
         end
         default:  cmd = '0;
      endcase
   end

endmodule

### hdl/itps_dp.sv
module itps_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  itps_pkg::cmd_type                    cmd,
   output itps_pkg::status_type                 status,
   input  logic [itps_pkg::RoomAccumWidth-1:0]  in_room_accum,
   input  logic [itps_pkg::ReadingWidth-1:0]    in_couple_reading,
   input  logic [itps_pkg::ReadingWidth-1:0]    in_resistive_reading,
   input  logic [itps_pkg::ReadingWidth-1:0]    in_target_temp,
   input  logic                                 csr_we,
   input  logic [itps_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [itps_pkg::CsrDataWidth-1:0]    csr_data,
   input  logic                                 out_ready,
   output logic                                 out_valid,
   output logic [itps_pkg::TipWidth-1:0]        out_tip_temp,
   output logic signed [itps_pkg::RoomWidth-1:0] out_room_temp,
   output logic [itps_pkg::DutyWidth-1:0]       out_duty
);
   import itps_pkg::*;

   // configuration
   logic        sensor_type_ff;
   logic [15:0] soft_gain_ff, soft_offset_ff, prop_coeff_ff, prev_coeff_ff;
   logic [7:0]  deriv_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_type_ff <= 1'b0;
         soft_gain_ff   <= SOFT_GAIN_RESET;
         soft_offset_ff <= '0;
         deriv_gain_ff  <= '0;
         prop_coeff_ff  <= '0;
         prev_coeff_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SENSOR_TYPE: sensor_type_ff <= csr_data[0];
            CSR_SOFT_GAIN:   soft_gain_ff   <= csr_data;
            CSR_SOFT_OFFSET: soft_offset_ff <= csr_data;
            CSR_DERIV_GAIN:  deriv_gain_ff  <= csr_data[7:0];
            CSR_PROP_COEFF:  prop_coeff_ff  <= csr_data;
            CSR_PREV_COEFF:  prev_coeff_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // captured transaction
   logic [RoomAccumWidth-1:0] acc_ff;
   logic [ReadingWidth-1:0]   raw_ff, target_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         acc_ff    <= in_room_accum;
         raw_ff    <= sensor_type_ff ? in_resistive_reading : in_couple_reading;
         target_ff <= in_target_temp;
      end
   end

   // state
   logic [15:0] temp_window_ff [4];
   logic [15:0] slope_window_ff [4];
   logic [15:0] window_sum_ff, fast_average_ff, slope_value_ff, last_error_ff, err_ff;
   logic [1:0]  window_pos_ff, slope_pos_ff;
   logic [23:0] duty_level_ff;
   logic        first_ff;
   logic signed [RoomWidth-1:0] room_ff;
   logic [TipWidth-1:0] tip_ff;
   logic signed [35:0] sum_ff;

   // shared multiplier
   logic signed [16:0] op_a, op_b;
   logic signed [33:0] product_ff;
   logic [10:0] room_base;
   logic [15:0] slope_mag;

   assign room_base = {1'b0, acc_ff[11:2]} - ROOM_BIAS;

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (cmd.mul_sel)
         MUL_ROOM: begin
            op_a = {{6{room_base[10]}}, room_base};
            op_b = ROOM_SCALE;
         end
         MUL_TIP: begin
            op_a = {soft_gain_ff[15], soft_gain_ff};
            op_b = {7'd0, raw_ff};
         end
         MUL_DTERM: begin
            op_a = {3'd0, slope_mag[15:2]};
            op_b = {9'd0, deriv_gain_ff};
         end
         MUL_CUR: begin
            op_a = {err_ff[15], err_ff};
            op_b = {1'b0, prop_coeff_ff};
         end
         MUL_PREV: begin
            op_a = {last_error_ff[15], last_error_ff};
            op_b = {1'b0, prev_coeff_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      product_ff <= op_a * op_b;
   end

   // tip scaling and clamp
   logic signed [17:0] tip_wide;
   logic [TipWidth-1:0] tip;

   always_comb begin
      tip_wide = {{2{product_ff[25]}}, product_ff[25:10]}
               + {{2{soft_offset_ff[15]}}, soft_offset_ff}
               + (sensor_type_ff ? 18'sd0 : {{7{room_ff[10]}}, room_ff});
      if (tip_wide < 0)
         tip = '0;
      else if (tip_wide > 18'sd32767)
         tip = '1;
      else
         tip = tip_wide[14:0];
   end

   // window and leaky average, primed by the first transaction
   logic [15:0] tip16, ws_base, ws_old, ws_new, fa_base;
   assign tip16   = {1'b0, tip};
   assign ws_base = first_ff ? {tip16[13:0], 2'b00} : window_sum_ff;
   assign ws_old  = first_ff ? tip16 : temp_window_ff[window_pos_ff];
   assign ws_new  = ws_base - ws_old + tip16;
   assign fa_base = first_ff ? {tip16[13:0], 2'b00} : fast_average_ff;

   // slope: leak, drop newest, add oldest
   logic [15:0] sv_base, sv_mag, sv_leak, sv_new;
   logic [1:0]  spos_next;
   assign spos_next = slope_pos_ff + 2'd1;
   assign sv_base   = first_ff ? 16'd0 : slope_value_ff;
   assign sv_mag    = sv_base[15] ? 16'd0 - sv_base : sv_base;
   assign sv_leak   = sv_base[15] ? 16'd0 - {2'b00, sv_mag[15:2]} : {2'b00, sv_mag[15:2]};
   assign sv_new    = sv_base - sv_leak - {2'b00, window_sum_ff[15:2]}
                    + slope_window_ff[spos_next];
   assign slope_mag = slope_value_ff[15] ? 16'd0 - slope_value_ff : slope_value_ff;

   // error
   logic [15:0] dterm, err_raw;
   always_comb begin
      dterm = slope_value_ff[15] ? 16'd0 - product_ff[17:2] : product_ff[17:2];
      err_raw = {6'd0, target_ff} - {{2{fast_average_ff[15]}}, fast_average_ff[15:2]} - dterm;
   end

   // duty shaping
   logic signed [35:0] p_sum;
   logic signed [14:0] over;
   logic [7:0]  shape, cap;
   logic [23:0] duty_in;

   always_comb begin
      p_sum = sum_ff - {{2{product_ff[33]}}, product_ff};
      over  = 15'sd0 - {err_ff[15], err_ff[15:2]};
      shape = (over >= 15'sd16) ? 8'hFF : {over[3:0], 4'h0};
      cap   = ~shape;
      if (p_sum < 0) begin
         duty_in = '0;
      end else begin
         duty_in = (p_sum > $signed({12'd0, DUTY_FULL})) ? DUTY_FULL : p_sum[23:0];
         if (over <= 15'sd0) begin
            if (over < OVER_FORCE_LIMIT)
               duty_in = DUTY_FULL;
         end else if (duty_in[23:16] > cap) begin
            duty_in = {cap, 16'hFFFF};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_sum_ff   <= '0;
         fast_average_ff <= '0;
         slope_value_ff  <= '0;
         last_error_ff   <= '0;
         duty_level_ff   <= '0;
         window_pos_ff   <= '0;
         slope_pos_ff    <= '0;
         first_ff        <= 1'b1;
         for (int i = 0; i < 4; i++) begin
            temp_window_ff[i]  <= '0;
            slope_window_ff[i] <= '0;
         end
      end else begin
         if (cmd.do_win) begin
            window_sum_ff   <= ws_new;
            fast_average_ff <= fa_base - {2'b00, fa_base[15:2]} + tip16;
            window_pos_ff   <= window_pos_ff + 2'd1;
            for (int i = 0; i < 4; i++) begin
               if (first_ff || 2'(i) == window_pos_ff)
                  temp_window_ff[i] <= tip16;
               if (2'(i) == slope_pos_ff)
                  slope_window_ff[i] <= {2'b00, ws_new[15:2]};
               else if (first_ff)
                  slope_window_ff[i] <= {2'b00, ws_base[15:2]};
            end
         end
         if (cmd.do_slope) begin
            slope_value_ff <= sv_new;
            slope_pos_ff   <= spos_next;
            first_ff       <= 1'b0;
         end
         if (cmd.finish) begin
            duty_level_ff <= duty_in;
            last_error_ff <= err_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_room)
         room_ff <= product_ff[18:8];
      if (cmd.do_win)
         tip_ff <= tip;
      if (cmd.do_err)
         err_ff <= {err_raw[13:0], 2'b00};
      if (cmd.do_sum)
         sum_ff <= {12'd0, duty_level_ff} + {{2{product_ff[33]}}, product_ff};
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (cmd.finish) begin
         out_valid <= 1'b1;
      end else if (out_ready) begin
         out_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_tip_temp  <= tip_ff;
         out_room_temp <= room_ff;
         out_duty      <= duty_in;
      end
   end

   assign status.out_free = !out_valid || out_ready;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

import itps_pkg::*;

typedef struct {
   logic [TipWidth-1:0]         tip;
   logic signed [RoomWidth-1:0] room;
   logic [DutyWidth-1:0]        duty;
} step_result_type;

class duty_scoreboard;
   logic                sensor_type;
   logic signed [15:0]  soft_gain;
   logic signed [15:0]  soft_offset;
   logic [7:0]          deriv_gain;
   logic [15:0]         prop_coeff;
   logic [15:0]         prev_coeff;

   logic [15:0] temp_win[4];
   logic [15:0] win_sum;
   logic [15:0] fast_avg;
   logic [1:0]  win_pos;
   logic [15:0] slope_win[4];
   logic [1:0]  slope_pos;
   logic [15:0] slope;
   logic [15:0] last_err;
   logic [23:0] duty_level;
   bit          priming;

   step_result_type expected_q[$];

   function new();
      sensor_type = 0;
      soft_gain   = SOFT_GAIN_RESET;
      soft_offset = 0;
      deriv_gain  = 0;
      prop_coeff  = 0;
      prev_coeff  = 0;
      for (int i = 0; i < 4; i++) begin
         temp_win[i]  = 0;
         slope_win[i] = 0;
      end
      win_sum    = 0;
      fast_avg   = 0;
      win_pos    = 0;
      slope_pos  = 0;
      slope      = 0;
      last_err   = 0;
      duty_level = 0;
      priming    = 1;
   endfunction

   function void write_reg(logic [CsrIndexWidth-1:0] idx, logic [15:0] data);
      case (idx)
         CSR_SENSOR_TYPE: sensor_type = data[0];
         CSR_SOFT_GAIN:   soft_gain   = data;
         CSR_SOFT_OFFSET: soft_offset = data;
         CSR_DERIV_GAIN:  deriv_gain  = data[7:0];
         CSR_PROP_COEFF:  prop_coeff  = data;
         CSR_PREV_COEFF:  prev_coeff  = data;
         default: ;
      endcase
   endfunction

   // one accepted request: advance the control state and queue the response
   function void note_request(logic [11:0] acc, logic [9:0] couple, logic [9:0] resist,
                              logic [9:0] target);
      int              room, raw, t, favg, over, s;
      logic [15:0]     tip, mag, leak, dterm, err;
      logic [1:0]      newest;
      bit              neg;
      longint          cur, prv, p;
      logic [23:0]     d;
      logic [7:0]      cap;
      step_result_type r;

      room = ((int'(acc) >> 2) - 125) * 182;
      room = room >>> 8;
      raw = sensor_type ? int'(resist) : int'(couple);
      t = ((int'(soft_gain) * raw) >>> 10) + int'(soft_offset);
      if (!sensor_type) t += room;
      if (t < 0) t = 0;
      if (t > 32767) t = 32767;
      tip = t[15:0];

      if (priming) begin
         win_sum = tip << 2;
         fast_avg = win_sum;
         for (int i = 0; i < 4; i++) begin
            temp_win[i]  = tip;
            slope_win[i] = win_sum >> 2;
         end
         slope = 0;
         priming = 0;
      end

      win_sum = win_sum - temp_win[win_pos] + tip;
      temp_win[win_pos] = tip;
      win_pos = win_pos + 2'd1;
      fast_avg = fast_avg - (fast_avg >> 2) + tip;

      slope_win[slope_pos] = win_sum >> 2;
      newest = slope_pos;
      slope_pos = slope_pos + 2'd1;

      // leak is the magnitude/4 with the slope's sign; slope is oldest minus newest
      neg  = slope[15];
      mag  = neg ? -slope : slope;
      mag  = mag >> 2;
      leak = neg ? -mag : mag;
      slope = slope - leak - slope_win[newest] + slope_win[slope_pos];

      neg   = slope[15];
      mag   = neg ? -slope : slope;
      mag   = mag >> 2;
      dterm = 16'((32'(mag) * 32'(deriv_gain)) >> 2);
      if (neg) dterm = -dterm;

      favg = int'($signed(fast_avg)) >>> 2;
      err  = 16'(int'(target) - favg) - dterm;
      err  = err << 2;

      cur = longint'($signed(err));
      prv = longint'($signed(last_err));
      last_err = err;
      p = longint'(duty_level) + cur * longint'(prop_coeff) - prv * longint'(prev_coeff);
      if (p < 0) begin
         d = 0;
      end else begin
         d = (p > 64'h00FF_FFFF) ? DUTY_FULL : p[23:0];
         over = -(int'(cur) >>> 2);
         if (over < -200) begin
            d = DUTY_FULL;
         end else if (over > 0) begin
            s = over * 16;
            if (s > 255) s = 255;
            cap = 8'(255 - s);
            if (d[23:16] > cap) d = {cap, 16'hFFFF};
         end
      end
      duty_level = d;

      r.tip  = tip[14:0];
      r.room = room[10:0];
      r.duty = d;
      expected_q.push_back(r);
   endfunction

   // returns the number of mismatching fields, with a description
   function int check_result(step_result_type got, output string msg);
      step_result_type e;
      int              bad;
      bad = 0;
      msg = "";
      if (expected_q.size() == 0) begin
         msg = $sformatf("response with nothing outstanding: tip=%0d room=%0d duty=%h",
                         got.tip, got.room, got.duty);
         return 1;
      end
      e = expected_q.pop_front();
      if (got.tip !== e.tip) begin
         bad++;
         msg = {msg, $sformatf(" tip got %0d exp %0d", got.tip, e.tip)};
      end
      if (got.room !== e.room) begin
         bad++;
         msg = {msg, $sformatf(" room got %0d exp %0d", got.room, e.room)};
      end
      if (got.duty !== e.duty) begin
         bad++;
         msg = {msg, $sformatf(" duty got %h exp %h", got.duty, e.duty)};
      end
      return bad;
   endfunction

   function int outstanding();
      return expected_q.size();
   endfunction
endclass

module tb_top;
   localparam int CycleLimit = 400000;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_data;

   itps_req_if req ();
   itps_rsp_if rsp ();

   iron_temperature_pid_step uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   duty_scoreboard sb;
   int  errors;
   int  n_sent;
   int  n_checked;
   int  stall_hold;
   int  cycles;

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   task automatic report(string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // leaves csr_we high; the caller lowers it after the last write
   task automatic write_csr(logic [CsrIndexWidth-1:0] idx, logic [15:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      sb.write_reg(idx, data);
      @(posedge clock);
   endtask

   task automatic set_config(logic st, logic [15:0] gain, logic [15:0] offs, logic [7:0] dg,
                             logic [15:0] pc, logic [15:0] vc);
      write_csr(CSR_SENSOR_TYPE, {15'd0, st});
      write_csr(CSR_SOFT_GAIN, gain);
      write_csr(CSR_SOFT_OFFSET, offs);
      write_csr(CSR_DERIV_GAIN, {8'd0, dg});
      write_csr(CSR_PROP_COEFF, pc);
      write_csr(CSR_PREV_COEFF, vc);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // stop offering so the last transaction is not taken twice
   task automatic drain();
      req.valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic send(logic [11:0] acc, logic [9:0] cpl, logic [9:0] res, logic [9:0] tgt,
                       bit allow_gap);
      int gap;
      req.valid             <= 1'b1;
      req.room_accum        <= acc;
      req.couple_reading    <= cpl;
      req.resistive_reading <= res;
      req.target_temp       <= tgt;
      do @(posedge clock); while (!req.ready);
      sb.note_request(acc, cpl, res, tgt);
      n_sent++;
      gap = allow_gap ? pick_gap() : 0;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // mostly plausible operating points near the target, with some wild ones
   task automatic random_items(int count, bit allow_gap);
      logic [9:0] tgt, rd;
      for (int i = 0; i < count; i++) begin
         tgt = 10'($urandom_range(0, 1023));
         if ($urandom_range(0, 3) != 0)
            rd = 10'(int'(tgt) / 2 + $urandom_range(0, 40));
         else
            rd = 10'($urandom_range(0, 1023));
         if ($urandom_range(0, 1))
            send(12'($urandom_range(0, 4092)), rd, 10'($urandom_range(0, 1023)), tgt,
                 allow_gap);
         else
            send(12'($urandom_range(0, 4092)), 10'($urandom_range(0, 1023)), rd, tgt,
                 allow_gap);
      end
   endtask

   // response side: random backpressure, plus a requested long hold-off
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_hold > 0) begin
            rsp.ready <= 1'b0;
            stall_hold--;
         end else if ($urandom_range(0, 9) < 7) begin
            rsp.ready <= 1'b1;
         end else begin
            rsp.ready <= 1'b0;
            if ($urandom_range(0, 19) == 0) stall_hold = $urandom_range(10, 40);
         end
      end
   end

   always @(posedge clock) begin
      step_result_type got;
      string           msg;
      if (!reset && rsp.valid && rsp.ready) begin
         got.tip  = rsp.tip_temp;
         got.room = rsp.room_temp;
         got.duty = rsp.duty;
         n_checked++;
         if (sb.check_result(got, msg) != 0) report(msg);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      sb         = new();
      errors     = 0;
      n_sent     = 0;
      n_checked  = 0;
      stall_hold = 0;
      cycles     = 0;
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      req.valid  = 1'b0;
      req.room_accum        = '0;
      req.couple_reading    = '0;
      req.resistive_reading = '0;
      req.target_temp       = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults: first transaction primes the windows
      send(12'd0, 10'd0, 10'd0, 10'd0, 0);
      send(12'd4092, 10'd1023, 10'd1023, 10'd1023, 0);
      send(12'd500, 10'd300, 10'd0, 10'd350, 1);
      drain();

      // all extremes: huge gain and offset, full coefficients
      set_config(1'b0, 16'h7FFF, 16'h7FFF, 8'hFF, 16'hFFFF, 16'hFFFF);
      send(12'd4092, 10'd1023, 10'd0, 10'd0, 0);
      send(12'd0, 10'd0, 10'd1023, 10'd1023, 0);
      send(12'd2048, 10'd512, 10'd512, 10'd512, 0);
      drain();
      set_config(1'b1, 16'h8000, 16'h8000, 8'hFF, 16'hFFFF, 16'h0000);
      send(12'd0, 10'd0, 10'd1023, 10'd1023, 0);
      send(12'd4092, 10'd1023, 10'd0, 10'd0, 0);
      send(12'd1000, 10'd0, 10'd1, 10'd700, 0);
      drain();
      // moderate loop gains: overshoot capping and forced full duty
      set_config(1'b1, 16'd1024, 16'd0, 8'd40, 16'd300, 16'd200);
      send(12'd600, 10'd0, 10'd100, 10'd900, 0);
      send(12'd600, 10'd0, 10'd400, 10'd420, 0);
      send(12'd600, 10'd0, 10'd430, 10'd420, 0);
      send(12'd600, 10'd0, 10'd500, 10'd420, 0);
      send(12'd600, 10'd0, 10'd300, 10'd420, 0);
      send(12'd600, 10'd0, 10'd419, 10'd420, 0);
      send(12'd600, 10'd0, 10'd1023, 10'd0, 0);
      drain();

      set_config(1'b0, 16'd1024, 16'd20, 8'd16, 16'd500, 16'd400);
      random_items(110, 1);
      drain();

      // long receiver hold-off while requests keep coming
      set_config(1'b1, 16'd900, 16'hFFF0, 8'd64, 16'd2000, 16'd1500);
      stall_hold = 300;
      random_items(110, 0);
      drain();

      set_config(1'b0, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)));
      random_items(100, 1);
      drain();

      set_config(1'b1, 16'd1100, 16'd5, 8'd255, 16'd40, 16'd30);
      random_items(110, 1);
      drain();

      set_config(1'b0, 16'h8000, 16'h7FFF, 8'd0, 16'hFFFF, 16'hFFFF);
      random_items(50, 1);
      drain();

      set_config(1'b1, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 8'($urandom_range(0, 255)), 16'($urandom_range(0, 2000)),
                 16'($urandom_range(0, 2000)));
      random_items(150, 1);
      req.valid <= 1'b0;
      drain();

      if (sb.outstanding() != 0) report($sformatf("%0d responses never arrived",
                                                  sb.outstanding()));
      $display("Covered %0d requests, %0d responses checked, both sensor types", n_sent,
               n_checked);
      $display("and 9 register settings including gain, offset and coefficient limits");
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", errors);
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
